// File: rtl/polynomial_sequence_hash_unit_macros.svh
// Assertion macros shared by the polynomial sequence hash checker.
`ifndef POLYNOMIAL_SEQUENCE_HASH_UNIT_MACROS_SVH
`define POLYNOMIAL_SEQUENCE_HASH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/psh_pkg.sv
// Package with the widths, codes and shared types of the polynomial sequence hash unit.
package psh_pkg;

  localparam int WORD_BITS = 64;
  localparam int MOD_BITS  = WORD_BITS - 1;
  localparam int CNT_W     = $clog2(WORD_BITS);
  localparam int MODE_W    = 2;
  localparam int PDATA_W   = 64;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_XOR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOD = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_HASH_MODE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ELEMENT_KEY = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MULTIPLIER  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MODULUS     = 2'd3;

  localparam logic [WORD_BITS-1:0] MULTIPLIER_RST = WORD_BITS'(64'd1837174919);
  localparam logic [MOD_BITS-1:0]  MODULUS_RST    = MOD_BITS'(64'd1000000007);

  typedef struct packed {
    logic start;
    logic mod_en;
  } psh_mul_ctl_t;

endpackage

// File: rtl/psh_mulu.sv
// Shared shift-add multiplier with optional reduction by a modulus, one operand bit per cycle.
module psh_mulu (
  input  logic                           clk,
  input  logic                           rst_n,
  input  psh_pkg::psh_mul_ctl_t          ctl,
  input  logic [psh_pkg::WORD_BITS-1:0]  opa,
  input  logic [psh_pkg::WORD_BITS-1:0]  opb,
  input  logic [psh_pkg::MOD_BITS-1:0]   modulus,
  output logic                           done,
  output logic [psh_pkg::WORD_BITS-1:0]  result
);
  import psh_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic                 mod_en_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [WORD_BITS-1:0] a_r;
  logic [WORD_BITS-1:0] b_r;
  logic [WORD_BITS-1:0] m_r;
  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0] dbl;
  logic [WORD_BITS-1:0] sum;

  always_comb begin
    dbl = {acc_r[WORD_BITS-2:0], 1'b0};
    if (mod_en_r && (dbl >= m_r)) begin
      dbl = dbl - m_r;
    end
    sum = dbl + (b_r[WORD_BITS-1] ? a_r : '0);
    if (mod_en_r && (sum >= m_r)) begin
      sum = sum - m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !ctl.start && busy_r && (cnt_r == '0);
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r      <= opa;
      b_r      <= opb;
      m_r      <= {{(WORD_BITS-MOD_BITS){1'b0}}, modulus};
      mod_en_r <= ctl.mod_en;
      acc_r    <= '0;
      cnt_r    <= CNT_W'(WORD_BITS - 1);
    end else if (busy_r) begin
      acc_r <= sum;
      b_r   <= {b_r[WORD_BITS-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

// File: rtl/polynomial_sequence_hash_unit.sv
// Top level of the polynomial sequence hash unit: configuration, sequencer and result register.
//
// Usage: sequence elements enter as beats on the in_ channel (in_element, in_last). A beat is
// taken when in_valid is high and in_stall is low. The unit works on one element at a time and
// holds in_stall high from the cycle after a beat is taken until that element is folded in.
// All products go through one shift-add multiplier that consumes one operand bit per cycle.
// Modes 0, 1 and 3 need two passes (term and power) for each element.
// Mode 2 needs four reducing passes (power, hash, term, power) for each element.
// Mode 2 with a modulus below two skips the multiplier.
// On the beat marked last the hash appears on out_hash_value with out_valid after the final
// pass, through the FIN state and the output register; the running state then returns to hash 0 and power 1.
// The result sits in an output register; while out_stall is high it holds, and the unit still
// takes and works on new elements. Only a further last element waits for the register to free.
// Registers are written over the APB port at byte addresses 0, 8, 16 and 24.
// Synchronous reset restores the register defaults and empties the pipeline.
module polynomial_sequence_hash_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [psh_pkg::WORD_BITS-1:0]  in_element,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [psh_pkg::WORD_BITS-1:0]  out_hash_value,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [psh_pkg::PADDR_W-1:0]    cfg_paddr,
  input  logic [psh_pkg::PDATA_W-1:0]    cfg_pwdata,
  output logic [psh_pkg::PDATA_W-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import psh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_HRED,
    ST_TERM,
    ST_POW,
    ST_FIN
  } state_t;

  localparam logic [WORD_BITS-1:0] WORD_ONE = WORD_BITS'(1);

  logic [MODE_W-1:0]    mode_r;
  logic [WORD_BITS-1:0] key_r;
  logic [WORD_BITS-1:0] mult_r;
  logic [MOD_BITS-1:0]  mod_r;

  state_t               state_r, state_nxt;
  psh_mul_ctl_t         ctl_r, ctl_nxt;
  logic [WORD_BITS-1:0] elem_r, elem_nxt;
  logic                 last_r, last_nxt;
  logic [WORD_BITS-1:0] hash_r, hash_nxt;
  logic [WORD_BITS-1:0] pow_r, pow_nxt;
  logic [WORD_BITS-1:0] pm_r, pm_nxt;
  logic [WORD_BITS-1:0] hm_r, hm_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_hash_r, out_hash_nxt;

  logic                 mod2;
  logic                 mod_small;
  logic [WORD_BITS-1:0] m_ext;
  logic [WORD_BITS-1:0] opa;
  logic [WORD_BITS-1:0] opb;
  logic                 mul_done;
  logic [WORD_BITS-1:0] mul_res;
  logic [WORD_BITS-1:0] msum;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign mod2      = (mode_r == MODE_MOD);
  assign mod_small = (mod_r[MOD_BITS-1:1] == '0);
  assign m_ext     = {{(WORD_BITS-MOD_BITS){1'b0}}, mod_r};

  always_comb begin
    case (state_r)
      ST_PRED: begin
        opa = WORD_ONE;
        opb = pow_r;
      end
      ST_HRED: begin
        opa = WORD_ONE;
        opb = hash_r;
      end
      ST_TERM: begin
        opa = mod2 ? pm_r : (elem_r ^ key_r);
        opb = mod2 ? elem_r : pow_r;
      end
      ST_POW: begin
        opa = mod2 ? pm_r : pow_r;
        opb = mult_r;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  psh_mulu u_mulu (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_r),
    .opa     (opa),
    .opb     (opb),
    .modulus (mod_r),
    .done    (mul_done),
    .result  (mul_res)
  );

  always_comb begin
    msum = hm_r + mul_res;
    if (msum >= m_ext) begin
      msum = msum - m_ext;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctl_nxt.start = 1'b0;
    ctl_nxt.mod_en = mod2;
    elem_nxt      = elem_r;
    last_nxt      = last_r;
    hash_nxt      = hash_r;
    pow_nxt       = pow_r;
    pm_nxt        = pm_r;
    hm_nxt        = hm_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hash_nxt  = out_hash_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          elem_nxt = in_element;
          last_nxt = in_last;
          if (mod2 && mod_small) begin
            hash_nxt  = '0;
            pow_nxt   = '0;
            state_nxt = ST_FIN;
          end else if (mod2) begin
            ctl_nxt.start = 1'b1;
            state_nxt     = ST_PRED;
          end else begin
            ctl_nxt.start = 1'b1;
            state_nxt     = ST_TERM;
          end
        end
      end
      ST_PRED: begin
        if (mul_done) begin
          pm_nxt        = mul_res;
          ctl_nxt.start = 1'b1;
          state_nxt     = ST_HRED;
        end
      end
      ST_HRED: begin
        if (mul_done) begin
          hm_nxt        = mul_res;
          ctl_nxt.start = 1'b1;
          state_nxt     = ST_TERM;
        end
      end
      ST_TERM: begin
        if (mul_done) begin
          if (mod2) begin
            hash_nxt = msum;
          end else if (mode_r == MODE_XOR) begin
            hash_nxt = hash_r ^ mul_res;
          end else begin
            hash_nxt = hash_r + mul_res;
          end
          ctl_nxt.start = 1'b1;
          state_nxt     = ST_POW;
        end
      end
      ST_POW: begin
        if (mul_done) begin
          pow_nxt   = mul_res;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = hash_r;
          hash_nxt      = '0;
          pow_nxt       = WORD_ONE;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctl_r       <= '0;
      hash_r      <= '0;
      pow_r       <= WORD_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctl_r       <= ctl_nxt;
      hash_r      <= hash_nxt;
      pow_r       <= pow_nxt;
      out_valid_r <= out_valid_nxt;
    end
    elem_r     <= elem_nxt;
    last_r     <= last_nxt;
    pm_r       <= pm_nxt;
    hm_r       <= hm_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[PADDR_W-1:PADDR_W-REG_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SUM;
      key_r  <= '0;
      mult_r <= MULTIPLIER_RST;
      mod_r  <= MODULUS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HASH_MODE:   mode_r <= cfg_pwdata[MODE_W-1:0];
        REG_ELEMENT_KEY: key_r  <= cfg_pwdata[WORD_BITS-1:0];
        REG_MULTIPLIER:  mult_r <= cfg_pwdata[WORD_BITS-1:0];
        REG_MODULUS:     mod_r  <= cfg_pwdata[MOD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HASH_MODE:   cfg_prdata = PDATA_W'(mode_r);
      REG_ELEMENT_KEY: cfg_prdata = PDATA_W'(key_r);
      REG_MULTIPLIER:  cfg_prdata = PDATA_W'(mult_r);
      REG_MODULUS:     cfg_prdata = PDATA_W'(mod_r);
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg_pready     = 1'b1;
  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

// File: rtl/psh_chk.sv
// Port-level checker for the polynomial sequence hash unit and its bind.
`include "polynomial_sequence_hash_unit_macros.svh"

module psh_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [psh_pkg::WORD_BITS-1:0]  out_hash_value
);
  import psh_pkg::*;

  logic in_beat;

  assign in_beat = in_valid && !in_stall;

  `PSH_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_hash_value), "stalled result beat changed")
  `PSH_ASSERT_NEXT(a_busy_after_beat, in_beat, in_stall,
                   "input not stalled while an element is in work")
  `PSH_ASSERT_NEXT(a_no_instant_result, in_beat, !$rose(out_valid),
                   "result appeared right after an input beat")
  `PSH_ASSERT_SAME(a_result_when_idle, $rose(out_valid), !in_stall,
                   "result appeared while the sequencer was busy")

endmodule

bind polynomial_sequence_hash_unit psh_chk u_psh_chk (.*);

// File: verif/polynomial_sequence_hash_unit_checker.sv
// Checker that predicts sequence hashes from observed beats and register writes and compares results.
module polynomial_sequence_hash_unit_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [psh_pkg::WORD_BITS-1:0] in_element,
  input  logic                          in_last,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [psh_pkg::WORD_BITS-1:0] out_hash_value,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic                          cfg_pready,
  input  logic [psh_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [psh_pkg::PDATA_W-1:0]   cfg_pwdata,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import psh_pkg::*;

  logic [MODE_W-1:0]    mode_q;
  logic [WORD_BITS-1:0] key_q;
  logic [WORD_BITS-1:0] mult_q;
  logic [MOD_BITS-1:0]  modulus_q;
  logic [WORD_BITS-1:0] hash_acc;
  logic [WORD_BITS-1:0] power_acc;
  logic [WORD_BITS-1:0] mod_w;
  logic [WORD_BITS-1:0] hash_w;
  logic [WORD_BITS-1:0] power_w;
  logic [WORD_BITS-1:0] term_w;
  logic [WORD_BITS-1:0] expected_hash;
  logic [WORD_BITS-1:0] hash_queue[$];

  // Exact modular product; the operands are already reduced below the modulus.
  function automatic logic [WORD_BITS-1:0] mul_reduce(input logic [WORD_BITS-1:0] a,
                                                      input logic [WORD_BITS-1:0] b,
                                                      input logic [WORD_BITS-1:0] m);
    logic [2*WORD_BITS-1:0] prod;
    prod = {{WORD_BITS{1'b0}}, a} * {{WORD_BITS{1'b0}}, b};
    return WORD_BITS'(prod % {{WORD_BITS{1'b0}}, m});
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q     = MODE_SUM;
      key_q      = '0;
      mult_q     = MULTIPLIER_RST;
      modulus_q  = MODULUS_RST;
      hash_acc   = '0;
      power_acc  = WORD_BITS'(64'd1);
      fail_count = 0;
      hash_queue.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[PADDR_W-1:3])
          REG_HASH_MODE:   mode_q    = cfg_pwdata[MODE_W-1:0];
          REG_ELEMENT_KEY: key_q     = cfg_pwdata[WORD_BITS-1:0];
          REG_MULTIPLIER:  mult_q    = cfg_pwdata[WORD_BITS-1:0];
          REG_MODULUS:     modulus_q = cfg_pwdata[MOD_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (hash_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected hash beat: actual %h", out_hash_value);
          fail_count++;
        end else begin
          expected_hash = hash_queue.pop_front();
          if (out_hash_value !== expected_hash) begin
            if (fail_count < 10)
              $display("hash mismatch: expected %h actual %h", expected_hash, out_hash_value);
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (mode_q == MODE_MOD) begin
          if (modulus_q < 2) begin
            hash_acc  = '0;
            power_acc = '0;
          end else begin
            mod_w   = {1'b0, modulus_q};
            hash_w  = hash_acc % mod_w;
            power_w = power_acc % mod_w;
            hash_w  = hash_w + mul_reduce(in_element % mod_w, power_w, mod_w);
            if (hash_w >= mod_w)
              hash_w = hash_w - mod_w;
            hash_acc  = hash_w;
            power_acc = mul_reduce(power_w, mult_q % mod_w, mod_w);
          end
        end else begin
          term_w = (in_element ^ key_q) * power_acc;
          if (mode_q == MODE_XOR)
            hash_acc = hash_acc ^ term_w;
          else
            hash_acc = hash_acc + term_w;
          power_acc = power_acc * mult_q;
        end
        if (in_last) begin
          hash_queue.push_back(hash_acc);
          hash_acc  = '0;
          power_acc = WORD_BITS'(64'd1);
        end
      end
    end
    pending_count <= hash_queue.size();
  end

endmodule

// File: verif/polynomial_sequence_hash_unit_test.sv
// Top of the polynomial sequence hash testbench: clock, reset, stimulus and verdict.
module polynomial_sequence_hash_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psh_pkg::*;

  localparam int SETTLE_CYCLES   = 600;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int RANDOM_ITEMS    = 1950;
  localparam int PHASES          = 12;
  localparam logic [MODE_W-1:0] MODE_SUM_ALIAS = 2'd3;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [WORD_BITS-1:0] in_element  = '0;
  logic                 in_last     = 1'b0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [WORD_BITS-1:0] out_hash_value;
  logic                 cfg_psel    = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0]   cfg_paddr   = '0;
  logic [PDATA_W-1:0]   cfg_pwdata  = '0;
  logic [PDATA_W-1:0]   cfg_prdata;
  logic                 cfg_pready;

  int fail_count;
  int pending_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  polynomial_sequence_hash_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_element     (in_element),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  polynomial_sequence_hash_unit_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_element     (in_element),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_pready     (cfg_pready),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("polynomial_sequence_hash_unit_test: errors");
    $finish;
  end

  function automatic logic [WORD_BITS-1:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return WORD_BITS'($urandom_range(255));
      3: return WORD_BITS'(64'd1) << $urandom_range(WORD_BITS - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_multiplier();
    case ($urandom_range(6))
      0: return '0;
      1: return WORD_BITS'(64'd1);
      2: return '1;
      3: return MULTIPLIER_RST;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // The top bit of a random modulus lands outside the 63-bit register.
  function automatic logic [WORD_BITS-1:0] rand_modulus();
    case ($urandom_range(7))
      0: return WORD_BITS'($urandom_range(1));
      1: return WORD_BITS'(64'd2);
      2: return {1'b0, {MOD_BITS{1'b1}}};
      3: return WORD_BITS'($urandom_range(1000, 2));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_beat(input logic [WORD_BITS-1:0] element, input logic last);
    logic stalled;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_element <= element;
    in_last    <= last;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    logic ready;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = cfg_pready;
      @(posedge clk);
    end while (!ready);
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic [WORD_BITS-1:0] key,
                           input logic [WORD_BITS-1:0] mult,
                           input logic [WORD_BITS-1:0] modulus);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_HASH_MODE, PDATA_W'(mode));
    write_reg(REG_ELEMENT_KEY, key);
    write_reg(REG_MULTIPLIER, mult);
    write_reg(REG_MODULUS, modulus);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    int count;
    int len;
    int budget;
    bit paused;
    logic [WORD_BITS-1:0] key;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat('1, 1'b0);
    send_beat('0, 1'b0);
    send_beat(64'h8000_0000_0000_0000, 1'b1);
    send_beat(64'd1, 1'b1);

    configure(MODE_XOR, '1, '1, {1'b0, MODULUS_RST});
    send_beat('0, 1'b0);
    send_beat(64'h5555_5555_5555_5555, 1'b0);
    send_beat('1, 1'b1);

    configure(MODE_SUM_ALIAS, 64'hAAAA_AAAA_AAAA_AAAA, '0, {1'b0, MODULUS_RST});
    send_beat(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_beat('0, 1'b0);
    send_beat('1, 1'b1);

    configure(MODE_MOD, '1, '1, {1'b0, {MOD_BITS{1'b1}}});
    send_beat('1, 1'b0);
    send_beat('1, 1'b1);

    configure(MODE_MOD, '0, MULTIPLIER_RST, 64'd2);
    send_beat('1, 1'b0);
    send_beat(64'd3, 1'b1);

    configure(MODE_MOD, '0, MULTIPLIER_RST, 64'd0);
    send_beat(64'd5, 1'b0);
    send_beat(64'd7, 1'b1);

    configure(MODE_MOD, '0, MULTIPLIER_RST, 64'd1);
    send_beat(64'd9, 1'b1);

    // The sequence switches to modular mode halfway and carries its state over.
    configure(MODE_SUM, 64'h0123_4567_89AB_CDEF, MULTIPLIER_RST, {1'b0, MODULUS_RST});
    send_beat('1, 1'b0);
    send_beat(64'd12345, 1'b0);
    configure(MODE_MOD, 64'h0123_4567_89AB_CDEF, MULTIPLIER_RST, {1'b0, MODULUS_RST});
    send_beat('1, 1'b1);

    budget = RANDOM_ITEMS / PHASES;
    for (int phase = 0; phase < PHASES; phase++) begin
      key = {$urandom, $urandom};
      configure(MODE_W'($urandom_range(3)), key, rand_multiplier(), rand_modulus());
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      if (phase == 5)
        hold_left = HOLD_OFF_CYCLES;
      count  = 0;
      paused = 1'b0;
      while (count < budget) begin
        len = ($urandom_range(9) == 0) ? int'($urandom_range(24, 8)) : int'($urandom_range(5, 1));
        for (int k = 1; k <= len; k++)
          send_beat(rand_word(), k == len);
        count += len;
        if (phase == 7 && !paused && count >= budget / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      // An unfinished sequence runs on under the next phase's settings.
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(3, 1))
          send_beat(rand_word(), 1'b0);
      end
    end
    send_beat(rand_word(), 1'b1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("polynomial_sequence_hash_unit_test: clean");
    end else begin
      $display("polynomial_sequence_hash_unit_test: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/psh_pkg.sv
rtl/psh_mulu.sv
rtl/polynomial_sequence_hash_unit.sv
rtl/psh_chk.sv
verif/polynomial_sequence_hash_unit_checker.sv
verif/polynomial_sequence_hash_unit_test.sv
